// ----- rtl/iorrq_pkg.sv -----
// Package: codes, sizes and word types of the reply release queue.
`default_nettype none

package iorrq_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_IMMEDIATE = 2'd0;
  localparam kind_t KIND_DELAYED   = 2'd1;
  localparam kind_t KIND_EXPIRED   = 2'd2;
  localparam kind_t KIND_UNUSED    = 2'd3;

  localparam status_t STATUS_RELEASED  = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;

  localparam int unsigned NUM_CONN_DEF    = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_BITS_DEF    = 8;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam int unsigned CONN_W = 3;
  localparam int unsigned TAG_W  = 8;

endpackage

`default_nettype wire

// ----- rtl/iorrq_if.sv -----
// Interfaces: request and result channels of the reply release queue.
`default_nettype none

interface iorrq_in_if;
  logic                     valid;
  logic                     ready;
  iorrq_pkg::kind_t         kind;
  logic [2:0]               connection;
  logic [7:0]               reply_tag;

  modport source (output valid, output kind, output connection, output reply_tag,
                  input ready);
  modport sink   (input valid, input kind, input connection, input reply_tag,
                  output ready);
endinterface

interface iorrq_out_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               out_connection;
  logic [7:0]               out_tag;
  iorrq_pkg::status_t       status;
  logic                     last;

  modport source (output valid, output out_connection, output out_tag, output status,
                  output last, input ready);
  modport sink   (input valid, input out_connection, input out_tag, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/iorrq_entry_store.sv -----
// Entry store: single-port-write, registered-read memory of queue entries.
`default_nettype none

module iorrq_entry_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 9
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/in_order_reply_release_queue_unit.sv -----
// Top level: per-connection in-order reply release queue with tag search sequencer.
//
//   channel   dir  word
//   request   in   kind, connection, reply_tag
//   result    out  out_connection, out_tag, status, last
//
// Immediate reply: the ready bits of the queued entries are scanned; it is released when
// all are ready, else queued as ready, or rejected when full. Delayed reply: queued or rejected.
// Expiry: the occupied entries of every connection are searched for the tag, then the ready
// entries at the head of its queue are released in order, each read from the entry store.
// Each result waits in the output register until taken; the sequencer stalls on it.
// Reset clears head/count per connection; the entry store is not cleared, since only
// occupied slots are ever read.
`default_nettype none

module in_order_reply_release_queue_unit #(
  parameter int unsigned NUM_CONN    = iorrq_pkg::NUM_CONN_DEF,
  parameter int unsigned QUEUE_DEPTH = iorrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = iorrq_pkg::TAG_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  iorrq_in_if.sink    request,
  iorrq_out_if.source result
);

  import iorrq_pkg::*;

  localparam int unsigned CW  = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
  localparam int unsigned DW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = NW + 1;
  localparam int unsigned ENT = NUM_CONN * QUEUE_DEPTH;
  localparam int unsigned AW  = $clog2(ENT);
  localparam int unsigned TW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int unsigned MW  = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SCHK = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_LAST = 3'd7;

  function automatic logic [DW-1:0] wrap(input logic [DW-1:0] h, input logic [NW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return DW'(s);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [DW-1:0] s);
    return AW'(int'(c) * QUEUE_DEPTH + int'(s));
  endfunction

  logic [2:0]      state, state_next;
  kind_t           kind_q;
  logic [2:0]      conn_q;
  logic [TW-1:0]   tag_q;
  logic [CW-1:0]   cur_conn;

  logic [DW-1:0]   head [NUM_CONN];
  logic [NW-1:0]   cnt  [NUM_CONN];

  logic [CW-1:0]   it_conn;
  logic [NW-1:0]   it_idx;
  logic            it_done;
  logic            pend;
  logic [NW-1:0]   pend_idx;
  logic [CW-1:0]   pend_conn;
  logic            all_rdy;
  logic [MW-1:0]   n;

  logic [2:0]      hold_conn;
  logic [TW-1:0]   hold_tag;
  status_t         hold_status;

  logic            out_valid;
  logic [2:0]      out_connection;
  logic [TAG_W-1:0] out_tag;
  status_t         status;
  logic            last;

  logic            rd_en;
  logic [CW-1:0]   rd_conn;
  logic [NW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr, rd_addr_q;
  logic [TW:0]     rd_word;
  logic [TW-1:0]   rd_tag;
  logic            rd_ready;

  logic            we;
  logic [AW-1:0]   wr_addr;
  logic [TW-1:0]   wr_tag;
  logic            wr_ready;

  logic            accept, out_free, conn_ok, full, match, it_has;
  logic [DW-1:0]   head_cur;
  logic [NW-1:0]   cnt_cur;
  logic            do_push, do_pop, hold_load, emit, emit_last;
  logic            srch_step, found, scan_inc, n_inc;
  logic [2:0]      hold_conn_next;
  logic [TW-1:0]   hold_tag_next;
  status_t         hold_status_next;

  assign accept   = request.valid && (state == S_IDLE) && !rst;
  assign out_free = !out_valid || result.ready;
  assign conn_ok  = int'(conn_q) < NUM_CONN;
  assign head_cur = head[cur_conn];
  assign cnt_cur  = cnt[cur_conn];
  assign full     = cnt_cur >= NW'(QUEUE_DEPTH);
  assign rd_tag   = rd_word[TW:1];
  assign rd_ready = rd_word[0];
  assign match    = pend && (rd_tag == tag_q);
  assign it_has   = it_idx < cnt[it_conn];
  assign rd_addr  = addr_of(rd_conn, wrap(head[rd_conn], rd_idx));

  iorrq_entry_store #(
    .DEPTH (ENT),
    .WIDTH (TW + 1)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata ({wr_tag, wr_ready}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_comb begin
    state_next       = state;
    rd_en            = 1'b0;
    rd_conn          = cur_conn;
    rd_idx           = '0;
    we               = 1'b0;
    wr_addr          = rd_addr_q;
    wr_tag           = rd_tag;
    wr_ready         = 1'b0;
    do_push          = 1'b0;
    do_pop           = 1'b0;
    hold_load        = 1'b0;
    hold_conn_next   = conn_q;
    hold_tag_next    = tag_q;
    hold_status_next = STATUS_RELEASED;
    emit             = 1'b0;
    emit_last        = 1'b0;
    srch_step        = 1'b0;
    found            = 1'b0;
    scan_inc         = 1'b0;
    n_inc            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DISP;
      end
      S_DISP: begin
        unique case (kind_q)
          KIND_IMMEDIATE: begin
            if (!conn_ok) begin
              hold_load        = 1'b1;
              hold_status_next = STATUS_FULL;
              state_next       = S_LAST;
            end else begin
              state_next = S_SCAN;
            end
          end
          KIND_DELAYED: begin
            if (!conn_ok || full) begin
              hold_load        = 1'b1;
              hold_status_next = STATUS_FULL;
              state_next       = S_LAST;
            end else begin
              we         = 1'b1;
              wr_addr    = addr_of(cur_conn, wrap(head_cur, cnt_cur));
              wr_tag     = tag_q;
              do_push    = 1'b1;
              state_next = S_IDLE;
            end
          end
          KIND_EXPIRED: state_next = S_SRCH;
          default:      state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (it_idx < cnt_cur) begin
          rd_en      = 1'b1;
          rd_idx     = it_idx;
          state_next = S_SCHK;
        end else begin
          hold_load  = 1'b1;
          state_next = S_LAST;
        end
      end
      S_SCHK: begin
        if (rd_ready) begin
          scan_inc   = 1'b1;
          state_next = S_SCAN;
        end else if (full) begin
          hold_load        = 1'b1;
          hold_status_next = STATUS_FULL;
          state_next       = S_LAST;
        end else begin
          we         = 1'b1;
          wr_addr    = addr_of(cur_conn, wrap(head_cur, cnt_cur));
          wr_tag     = tag_q;
          wr_ready   = 1'b1;
          do_push    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        if (match) begin
          we         = 1'b1;
          wr_ready   = 1'b1;
          found      = 1'b1;
          state_next = ((pend_idx == '0) || all_rdy) ? S_RD : S_IDLE;
        end else if (it_done && !pend) begin
          hold_load        = 1'b1;
          hold_conn_next   = '0;
          hold_status_next = STATUS_NOT_FOUND;
          state_next       = S_LAST;
        end else begin
          srch_step = 1'b1;
          rd_en     = !it_done && it_has;
          rd_conn   = it_conn;
          rd_idx    = it_idx;
        end
      end
      S_RD: begin
        if ((cnt_cur == '0) || (n == MW'(MAX_RESULTS))) begin
          state_next = S_LAST;
        end else begin
          rd_en      = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!rd_ready) begin
          state_next = S_LAST;
        end else if ((n == '0) || out_free) begin
          emit             = (n != '0);
          hold_load        = 1'b1;
          hold_conn_next   = 3'(cur_conn);
          hold_tag_next    = rd_tag;
          we               = 1'b1;
          do_pop           = 1'b1;
          n_inc            = 1'b1;
          state_next       = S_RD;
        end
      end
      S_LAST: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_addr_q <= rd_addr;
    if (hold_load) begin
      hold_conn   <= hold_conn_next;
      hold_tag    <= hold_tag_next;
      hold_status <= hold_status_next;
    end
    if (accept) begin
      kind_q   <= request.kind;
      conn_q   <= request.connection;
      tag_q    <= TW'(request.reply_tag);
      cur_conn <= CW'(request.connection);
      it_conn  <= '0;
      it_idx   <= '0;
      it_done  <= 1'b0;
      pend     <= 1'b0;
      all_rdy  <= 1'b1;
    end
    if (scan_inc) it_idx <= it_idx + NW'(1);
    if (srch_step) begin
      if (pend) all_rdy <= ((pend_idx == '0) || all_rdy) && rd_ready;
      pend <= !it_done && it_has;
      if (!it_done) begin
        if (it_has) begin
          pend_conn <= it_conn;
          pend_idx  <= it_idx;
          it_idx    <= it_idx + NW'(1);
        end else if (it_conn == CW'(NUM_CONN - 1)) begin
          it_done <= 1'b1;
        end else begin
          it_conn <= it_conn + CW'(1);
          it_idx  <= '0;
        end
      end
    end
    if (found) begin
      cur_conn <= pend_conn;
      n        <= '0;
    end
    if (n_inc) n <= n + MW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CONN; k++) begin
        head[k] <= '0;
        cnt[k]  <= '0;
      end
    end else begin
      if (do_push) cnt[cur_conn] <= cnt_cur + NW'(1);
      if (do_pop) begin
        head[cur_conn] <= wrap(head_cur, NW'(1));
        cnt[cur_conn]  <= cnt_cur - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_connection <= hold_conn;
      out_tag        <= TAG_W'(hold_tag);
      status         <= hold_status;
      last           <= emit_last;
    end
  end

  assign request.ready         = (state == S_IDLE) && !rst;
  assign result.valid          = out_valid;
  assign result.out_connection = out_connection;
  assign result.out_tag        = out_tag;
  assign result.status         = status;
  assign result.last           = last;

endmodule

`default_nettype wire

// ----- rtl/iorrq_checker.sv -----
// Checker: port-level assertions on the result channel, bound to the top level.
`default_nettype none

module iorrq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_connection,
  input wire logic [7:0] out_tag,
  input wire logic [1:0] status,
  input wire logic       last
);

  import iorrq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(status)
      && $stable(last) && $stable(out_connection))
    else $error("stalled result word changed");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_RELEASED) |-> last)
    else $error("rejection word not marked last");

  a_not_found_conn: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NOT_FOUND) |-> (out_connection == 3'd0))
    else $error("tag-not-found word carries a connection");

endmodule

bind in_order_reply_release_queue_unit iorrq_checker u_iorrq_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_connection (result.out_connection),
  .out_tag        (result.out_tag),
  .status         (result.status),
  .last           (result.last)
);

`default_nettype wire

// ----- sim/in_order_reply_release_queue_unit_test.sv -----
// Testbench: in-order reply release queue unit checked against its own predictor.
`timescale 1ns / 1ps

module in_order_reply_release_queue_unit_test;
  import iorrq_pkg::*;

  localparam int unsigned NCONN        = NUM_CONN_DEF;
  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS = 170;
  localparam int unsigned CALM_TAIL    = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 300;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_FILLS    = 3;
  localparam int unsigned PLAN_LEN     = 22;

  typedef struct packed {
    logic [2:0] conn;
    logic [7:0] tag;
    status_t    status;
    logic       last;
  } reply_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  conn;
    logic [7:0]  tag;
    logic        typed;
    reply_word_t want;
  } plan_row_t;

  // typed rows carry the obvious answer; the rest go through the predictor
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{KIND_EXPIRED,   3'd0, 8'h00, 1'b1, '{3'd0, 8'h00, STATUS_NOT_FOUND, 1'b1}},
    '{KIND_EXPIRED,   3'd5, 8'hFF, 1'b1, '{3'd0, 8'hFF, STATUS_NOT_FOUND, 1'b1}},
    '{KIND_IMMEDIATE, 3'd0, 8'h00, 1'b1, '{3'd0, 8'h00, STATUS_RELEASED,  1'b1}},
    '{KIND_IMMEDIATE, 3'd7, 8'hFF, 1'b1, '{3'd7, 8'hFF, STATUS_RELEASED,  1'b1}},
    '{KIND_UNUSED,    3'd5, 8'hAA, 1'b0, '0},
    '{KIND_DELAYED,   3'd3, 8'h10, 1'b0, '0},
    '{KIND_IMMEDIATE, 3'd3, 8'h11, 1'b0, '0},
    '{KIND_DELAYED,   3'd3, 8'h12, 1'b0, '0},
    '{KIND_EXPIRED,   3'd0, 8'h12, 1'b0, '0},
    '{KIND_EXPIRED,   3'd0, 8'h10, 1'b0, '0},
    '{KIND_DELAYED,   3'd1, 8'h20, 1'b0, '0},
    '{KIND_DELAYED,   3'd2, 8'h20, 1'b0, '0},
    '{KIND_DELAYED,   3'd1, 8'h21, 1'b0, '0},
    '{KIND_EXPIRED,   3'd0, 8'h21, 1'b0, '0},
    '{KIND_EXPIRED,   3'd0, 8'h20, 1'b0, '0},
    '{KIND_EXPIRED,   3'd6, 8'h20, 1'b0, '0},
    '{KIND_EXPIRED,   3'd0, 8'h20, 1'b1, '{3'd0, 8'h20, STATUS_NOT_FOUND, 1'b1}},
    '{KIND_DELAYED,   3'd4, 8'h7F, 1'b0, '0},
    '{KIND_IMMEDIATE, 3'd4, 8'h80, 1'b0, '0},
    '{KIND_IMMEDIATE, 3'd4, 8'h81, 1'b0, '0},
    '{KIND_EXPIRED,   3'd2, 8'h7F, 1'b0, '0},
    '{KIND_UNUSED,    3'd2, 8'h55, 1'b0, '0}
  };

  logic clk;
  logic rst;

  iorrq_in_if  request_ch ();
  iorrq_out_if result_ch ();

  in_order_reply_release_queue_unit dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  // predictor state
  logic [7:0]  slot_tag   [NCONN][DEPTH];
  bit          slot_ready [NCONN][DEPTH];
  int unsigned q_head     [NCONN];
  int unsigned q_count    [NCONN];

  reply_word_t due_replies [$];
  reply_word_t step_replies [$];

  bit          gaps_on;
  bit          stalls_on;
  bit          hold_req;
  int unsigned cycle_count;
  int unsigned fault_count;
  int unsigned checked_count;
  int unsigned released_count;
  int unsigned full_count;
  int unsigned missing_count;
  int unsigned words_sent;
  int unsigned longest_run;

  function automatic reply_word_t mk_reply(logic [2:0] c, logic [7:0] t, status_t s,
                                           logic l);
    reply_word_t w;
    w.conn   = c;
    w.tag    = t;
    w.status = s;
    w.last   = l;
    return w;
  endfunction

  function automatic bit front_ready(int unsigned c, int unsigned upto);
    bit ok;
    ok = 1'b1;
    for (int unsigned i = 0; i < upto; i++) begin
      if (!slot_ready[c][(q_head[c] + i) % DEPTH]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void release_order_step(kind_t k, logic [2:0] c, logic [7:0] t);
    int unsigned hc, hi, s, n;
    bit          found;
    step_replies.delete();
    found = 1'b0;
    hc = 0;
    hi = 0;
    n = 0;
    if (k == KIND_IMMEDIATE || k == KIND_DELAYED) begin
      if (k == KIND_IMMEDIATE && front_ready(c, q_count[c])) begin
        step_replies = {step_replies, mk_reply(c, t, STATUS_RELEASED, 1'b1)};
      end else if (q_count[c] >= DEPTH) begin
        step_replies = {step_replies, mk_reply(c, t, STATUS_FULL, 1'b1)};
      end else begin
        s = (q_head[c] + q_count[c]) % DEPTH;
        slot_tag[c][s]   = t;
        slot_ready[c][s] = (k == KIND_IMMEDIATE);
        q_count[c]++;
      end
    end else if (k == KIND_EXPIRED) begin
      for (int unsigned cc = 0; cc < NCONN && !found; cc++) begin
        for (int unsigned i = 0; i < q_count[cc] && !found; i++) begin
          if (slot_tag[cc][(q_head[cc] + i) % DEPTH] == t) begin
            found = 1'b1;
            hc = cc;
            hi = i;
          end
        end
      end
      if (!found) begin
        step_replies = {step_replies, mk_reply(3'd0, t, STATUS_NOT_FOUND, 1'b1)};
      end else begin
        slot_ready[hc][(q_head[hc] + hi) % DEPTH] = 1'b1;
        if (front_ready(hc, hi)) begin
          while (q_count[hc] > 0 && n < MAX_RESULTS && slot_ready[hc][q_head[hc]]) begin
            step_replies = {step_replies, mk_reply(hc[2:0], slot_tag[hc][q_head[hc]],
                                                   STATUS_RELEASED, 1'b0)};
            slot_ready[hc][q_head[hc]] = 1'b0;
            q_head[hc] = (q_head[hc] + 1) % DEPTH;
            q_count[hc]--;
            n++;
          end
          if (n > 0) step_replies[n - 1].last = 1'b1;
        end
      end
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(kind_t k, logic [2:0] c, logic [7:0] t, logic typed,
                           reply_word_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.kind       <= k;
    request_ch.connection <= c;
    request_ch.reply_tag  <= t;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    release_order_step(k, c, t);
    if (typed) due_replies = {due_replies, want};
    else foreach (step_replies[i]) due_replies = {due_replies, step_replies[i]};
    if (step_replies.size() > longest_run) longest_run = step_replies.size();
    if (k != KIND_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    request_ch.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d words still due", cycle_count,
             due_replies.size());
    $display("** in_order_reply_release_queue_unit: FAILED **");
    $finish;
  end

  // result sink: random stall bursts, plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_word_t got, want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = mk_reply(result_ch.out_connection, result_ch.out_tag, result_ch.status,
                     result_ch.last);
      checked_count++;
      case (got.status)
        STATUS_RELEASED:  released_count++;
        STATUS_FULL:      full_count++;
        STATUS_NOT_FOUND: missing_count++;
        default: ;
      endcase
      if (due_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected word: conn=%0d tag=%02h status=%0d last=%0d",
                   got.conn, got.tag, got.status, got.last);
      end else begin
        want = due_replies[0];
        due_replies.delete(0);
        if (got.conn !== want.conn || got.tag !== want.tag ||
            got.status !== want.status || got.last !== want.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display({"mismatch: want conn=%0d tag=%02h status=%0d last=%0d, ",
                      "got conn=%0d tag=%02h status=%0d last=%0d"},
                     want.conn, want.tag, want.status, want.last,
                     got.conn, got.tag, got.status, got.last);
        end
      end
    end
  end

  initial begin
    int unsigned rnd, c, i, n, sent_random, fills_done;
    logic [7:0]  head_tag, tmp;
    logic [7:0]  order [DEPTH];
    rst                   = 1'b1;
    request_ch.valid      = 1'b0;
    request_ch.kind       = KIND_IMMEDIATE;
    request_ch.connection = '0;
    request_ch.reply_tag  = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    hold_req    = 1'b0;
    sent_random = 0;
    fills_done  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (PLAN[r])
      send_word(PLAN[r].kind, PLAN[r].conn, PLAN[r].tag, PLAN[r].typed, PLAN[r].want);
    drain_replies();

    // back-pressure: sink holds off while words keep coming
    hold_req = 1'b1;
    for (i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_word(KIND_IMMEDIATE, 3'($urandom_range(0, 7)),
                                8'($urandom_range(0, 255)), 1'b0, '0);
      else send_word(KIND_EXPIRED, 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 1'b0, '0);
    end
    drain_replies();

    while (sent_random < RANDOM_WORDS) begin
      n = words_sent;
      if (sent_random % 25 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (sent_random + CALM_TAIL >= RANDOM_WORDS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      rnd = $urandom_range(0, 99);
      c   = $urandom_range(0, NCONN - 1);
      if (rnd < 6 && fills_done < MAX_FILLS) begin
        // fill a queue, hit it while full, then expire so the head goes last
        fills_done++;
        while (q_count[c] < DEPTH)
          send_word(KIND_DELAYED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
        send_word(KIND_DELAYED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
        send_word(KIND_IMMEDIATE, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
        head_tag = slot_tag[c][q_head[c]];
        for (i = 1; i < DEPTH; i++) order[i] = slot_tag[c][(q_head[c] + i) % DEPTH];
        for (i = DEPTH - 1; i > 1; i--) begin
          rnd = $urandom_range(1, i);
          tmp = order[i];
          order[i] = order[rnd];
          order[rnd] = tmp;
        end
        for (i = 1; i < DEPTH; i++)
          send_word(KIND_EXPIRED, 3'($urandom_range(0, 7)), order[i], 1'b0, '0);
        send_word(KIND_EXPIRED, 3'($urandom_range(0, 7)), head_tag, 1'b0, '0);
      end else if (rnd < 10) begin
        send_word(KIND_UNUSED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (rnd < 32) begin
        send_word(KIND_IMMEDIATE, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (rnd < 60) begin
        send_word(KIND_DELAYED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (rnd < 90) begin
        for (i = 0; i < NCONN && q_count[c] == 0; i++) c = (c + 1) % NCONN;
        if (q_count[c] == 0) begin
          send_word(KIND_EXPIRED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          i = $urandom_range(0, q_count[c] - 1);
          send_word(KIND_EXPIRED, 3'($urandom_range(0, 7)),
                    slot_tag[c][(q_head[c] + i) % DEPTH], 1'b0, '0);
        end
      end else begin
        send_word(KIND_EXPIRED, c[2:0], 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      sent_random += words_sent - n;
    end
    drain_replies();

    $display("sent %0d words incl. directed, back-pressure and %0d queue fills",
             words_sent, fills_done);
    $display("checked %0d words: %0d released, %0d full, %0d not found; longest run %0d",
             checked_count, released_count, full_count, missing_count, longest_run);
    if (fault_count == 0 && due_replies.size() == 0) begin
      $display("** in_order_reply_release_queue_unit: PASSED **");
    end else begin
      $display("%0d faults, %0d words still due", fault_count, due_replies.size());
      $display("** in_order_reply_release_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/iorrq_pkg.sv
rtl/iorrq_if.sv
rtl/iorrq_entry_store.sv
rtl/in_order_reply_release_queue_unit.sv
rtl/iorrq_checker.sv
sim/in_order_reply_release_queue_unit_test.sv
